// File: src/civil_date_day_number_convert_defines.svh
// Assertion macros for the civil date / day number converter.
// Used by the top level only; the macros expect signals named clk and rst in scope.
`ifndef CIVIL_DATE_DAY_NUMBER_CONVERT_DEFINES_SVH
`define CIVIL_DATE_DAY_NUMBER_CONVERT_DEFINES_SVH
`ifndef SYNTHESIS
`define CDC_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("civil date convert: same-cycle check failed");
`define CDC_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("civil date convert: next-cycle check failed");
`else
`define CDC_ASSERT_IMP(label, ante, cons)
`define CDC_ASSERT_NXT(label, ante, cons)
`endif
`endif

// File: src/cdc_pkg.sv
// Shared types and constants for the civil date / day number converter.
// No dependencies; imported by the datapath modules and the top level.
`timescale 1ns / 1ps

package cdc_pkg;

  // Register stages in each datapath, ahead of the output register.
  localparam int unsigned NumStages = 9;

  typedef struct packed {
    logic [NumStages-1:0] load;
  } pipe_ctrl_t;

  localparam logic [21:0] EpochShift = 22'd719468;
  localparam logic [17:0] EraDays    = 18'd146097;
  localparam logic [13:0] EraYears   = 14'd400;
  localparam logic signed [22:0] DnMin = -23'sd719162;
  localparam logic signed [22:0] DnMax = 23'sd2932896;

  // Reciprocals for division by constants: floor(x / D) = (x * ceil(2^S / D)) >> S,
  // exact whenever x * (D - 1) < 2^S over the range of x.
  localparam int unsigned Div100YShift = 21;
  localparam logic [14:0] Div100YRecip =
    15'(((64'd1 << Div100YShift) + 64'd99) / 64'd100);
  localparam int unsigned EraShift = 40;
  localparam logic [22:0] EraRecip =
    23'(((64'd1 << EraShift) + 64'd146096) / 64'd146097);
  localparam int unsigned Div1460Shift = 28;
  localparam logic [17:0] Div1460Recip =
    18'(((64'd1 << Div1460Shift) + 64'd1459) / 64'd1460);
  localparam int unsigned Div36524Shift = 33;
  localparam logic [17:0] Div36524Recip =
    18'(((64'd1 << Div36524Shift) + 64'd36523) / 64'd36524);
  localparam int unsigned Div365Shift = 26;
  localparam logic [17:0] Div365Recip =
    18'(((64'd1 << Div365Shift) + 64'd364) / 64'd365);
  localparam int unsigned Div100SShift = 16;
  localparam logic [9:0] Div100SRecip =
    10'(((64'd1 << Div100SShift) + 64'd99) / 64'd100);
  localparam int unsigned Div153Shift = 19;
  localparam logic [11:0] Div153Recip =
    12'(((64'd1 << Div153Shift) + 64'd152) / 64'd153);

  // Days before the first of each month, counting from March.
  function automatic logic [8:0] cum_days(input logic [3:0] idx);
    logic [8:0] r;
    case (idx)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

// File: src/cdc_to_days.sv
// Date to day number datapath: validity check and day count in four stages,
// then a delay line to match the other direction's depth. Depends on cdc_pkg.
`timescale 1ns / 1ps

module cdc_to_days import cdc_pkg::*; (
  input  logic        clk,
  input  pipe_ctrl_t  ctrl,
  input  logic [13:0] year_in,
  input  logic [3:0]  month_in,
  input  logic [4:0]  day_in,
  output logic [22:0] day_number,
  output logic        ok
);

  localparam int unsigned FirstDelay = 4;

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] r;
    case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: r = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                     r = 5'd30;
      4'd2:    r = leap ? 5'd29 : 5'd28;
      default: r = 5'd0;
    endcase
    return r;
  endfunction

  // Stage A: year divided by 100.
  logic [28:0] q_prod;
  logic [13:0] a_y;
  logic [3:0]  a_m;
  logic [4:0]  a_d;
  logic [7:0]  a_q;

  assign q_prod = 29'(year_in) * 29'(Div100YRecip);

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      a_y <= year_in;
      a_m <= month_in;
      a_d <= day_in;
      a_q <= q_prod[28:21];
    end
  end

  // Stage B: leap rule, validity, and the March-based year.
  logic [13:0] r_prod;
  logic [6:0]  r100;
  logic        leap;
  logic        before_mar;
  logic        date_ok;
  logic [13:0] b_yy;
  logic [7:0]  b_qyy;
  logic [3:0]  b_s;
  logic [4:0]  b_d;
  logic        b_ok;

  assign r_prod     = 14'(a_q) * 14'd100;
  assign r100       = 7'(a_y - r_prod);
  assign leap       = ((a_y[1:0] == 2'd0) && (r100 != 7'd0)) ||
                      ((r100 == 7'd0) && (a_q[1:0] == 2'd0));
  assign before_mar = (a_m <= 4'd2);
  assign date_ok    = (a_y >= 14'd1) && (a_y <= 14'd9999) &&
                      (a_d >= 5'd1) && (a_d <= month_len(a_m, leap));

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      b_yy  <= a_y - 14'(before_mar);
      // Stepping back a year from a multiple of 100 drops the century count.
      b_qyy <= a_q - 8'(before_mar && (r100 == 7'd0));
      b_s   <= before_mar ? (a_m + 4'd9) : (a_m - 4'd3);
      b_d   <= a_d;
      b_ok  <= date_ok;
    end
  end

  // Stage C: days of whole years, and days within the year.
  logic [21:0] c_a;
  logic [8:0]  c_b;
  logic        c_ok;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      c_a  <= 22'(b_yy) * 22'd365 + 22'(b_yy >> 2) - 22'(b_qyy) + 22'(b_qyy >> 2);
      c_b  <= cum_days(b_s) + 9'(b_d);
      c_ok <= b_ok;
    end
  end

  // Stage D onward: final sum, then delay registers.
  logic [21:0] sum_days;
  logic [22:0] dn_pipe [FirstDelay-1:NumStages-1];
  logic        ok_pipe [FirstDelay-1:NumStages-1];

  assign sum_days = c_a + 22'(c_b);

  always_ff @(posedge clk) begin
    if (ctrl.load[FirstDelay-1]) begin
      // Day one of the month counts as zero, hence the extra one.
      dn_pipe[FirstDelay-1] <= 23'(sum_days) - 23'(EpochShift) - 23'd1;
      ok_pipe[FirstDelay-1] <= c_ok;
    end
    for (int k = FirstDelay; k < NumStages; k++) begin
      if (ctrl.load[k]) begin
        dn_pipe[k] <= dn_pipe[k-1];
        ok_pipe[k] <= ok_pipe[k-1];
      end
    end
  end

  assign day_number = dn_pipe[NumStages-1];
  assign ok         = ok_pipe[NumStages-1];

endmodule

// File: src/cdc_from_days.sv
// Day number to date datapath: era split, year of era, day of year and month
// over nine register stages with a final combinational step. Depends on cdc_pkg.
`timescale 1ns / 1ps

module cdc_from_days import cdc_pkg::*; (
  input  logic               clk,
  input  pipe_ctrl_t         ctrl,
  input  logic signed [22:0] day_number_in,
  output logic [13:0]        year,
  output logic [3:0]         month,
  output logic [4:0]         day,
  output logic               ok
);

  // Stage A: shift to a count from 0000-03-01 and range check.
  logic [23:0] zz_full;
  logic [21:0] a_zz;
  logic        a_rng;

  assign zz_full = 24'({day_number_in[22], day_number_in}) + 24'(EpochShift);

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      a_zz  <= zz_full[21:0];
      a_rng <= (day_number_in >= DnMin) && (day_number_in <= DnMax);
    end
  end

  // Stage B: 400-year era.
  logic [44:0] era_prod;
  logic [21:0] b_zz;
  logic [4:0]  b_era;
  logic        b_rng;

  assign era_prod = 45'(a_zz) * 45'(EraRecip);

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      b_zz  <= a_zz;
      b_era <= era_prod[44:40];
      b_rng <= a_rng;
    end
  end

  // Stage C: day of era.
  logic [17:0] c_doe;
  logic [4:0]  c_era;
  logic        c_rng;

  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      c_doe <= 18'(b_zz - 22'(b_era) * 22'(EraDays));
      c_era <= b_era;
      c_rng <= b_rng;
    end
  end

  // Stage D: leap day corrections within the era.
  logic [35:0] p1460;
  logic [35:0] p36524;
  logic [7:0]  d_q1460;
  logic [2:0]  d_q36524;
  logic        d_last;
  logic [17:0] d_doe;
  logic [4:0]  d_era;
  logic        d_rng;

  assign p1460  = 36'(c_doe) * 36'(Div1460Recip);
  assign p36524 = 36'(c_doe) * 36'(Div36524Recip);

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      d_q1460  <= p1460[35:28];
      d_q36524 <= p36524[35:33];
      d_last   <= (c_doe == 18'd146096);
      d_doe    <= c_doe;
      d_era    <= c_era;
      d_rng    <= c_rng;
    end
  end

  // Stage E: day of era with leap days removed.
  logic [17:0] e_num;
  logic [17:0] e_doe;
  logic [4:0]  e_era;
  logic        e_rng;

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      e_num <= d_doe - 18'(d_q1460) + 18'(d_q36524) - 18'(d_last);
      e_doe <= d_doe;
      e_era <= d_era;
      e_rng <= d_rng;
    end
  end

  // Stage F: year of era.
  logic [35:0] p365;
  logic [8:0]  f_yoe;
  logic [17:0] f_doe;
  logic [4:0]  f_era;
  logic        f_rng;

  assign p365 = 36'(e_num) * 36'(Div365Recip);

  always_ff @(posedge clk) begin
    if (ctrl.load[5]) begin
      f_yoe <= p365[34:26];
      f_doe <= e_doe;
      f_era <= e_era;
      f_rng <= e_rng;
    end
  end

  // Stage G: days before the year of era, and the March-based year.
  logic [18:0] p100;
  logic [2:0]  g_yq100;
  logic [17:0] g_y365;
  logic [13:0] g_yr;
  logic [17:0] g_doe;
  logic        g_rng;

  assign p100 = 19'(f_yoe) * 19'(Div100SRecip);

  always_ff @(posedge clk) begin
    if (ctrl.load[6]) begin
      g_yq100 <= p100[18:16];
      g_y365  <= 18'(f_yoe) * 18'd365 + 18'(f_yoe >> 2);
      g_yr    <= 14'(f_yoe) + 14'(f_era) * EraYears;
      g_doe   <= f_doe;
      g_rng   <= f_rng;
    end
  end

  // Stage H: day of year, counted from March 1.
  logic [17:0] doy_full;
  logic [8:0]  h_doy;
  logic [13:0] h_yr;
  logic        h_rng;

  assign doy_full = g_doe - g_y365 + 18'(g_yq100);

  always_ff @(posedge clk) begin
    if (ctrl.load[7]) begin
      h_doy <= doy_full[8:0];
      h_yr  <= g_yr;
      h_rng <= g_rng;
    end
  end

  // Stage I: month index from March.
  logic [11:0] mp_arg;
  logic [23:0] p153;
  logic [3:0]  i_mp;
  logic [8:0]  i_doy;
  logic [13:0] i_yr;
  logic        i_rng;

  assign mp_arg = 12'(h_doy) * 12'd5 + 12'd2;
  assign p153   = 24'(mp_arg) * 24'(Div153Recip);

  always_ff @(posedge clk) begin
    if (ctrl.load[8]) begin
      i_mp  <= p153[22:19];
      i_doy <= h_doy;
      i_yr  <= h_yr;
      i_rng <= h_rng;
    end
  end

  // January and February belong to the next calendar year.
  logic [8:0] dom;

  assign dom   = i_doy - cum_days(i_mp) + 9'd1;
  assign month = (i_mp < 4'd10) ? (i_mp + 4'd3) : (i_mp - 4'd9);
  assign day   = dom[4:0];
  assign year  = i_yr + 14'(month <= 4'd2);
  assign ok    = i_rng;

endmodule

// File: src/civil_date_day_number_convert.sv
// Each request passes through 9 datapath stages and then the output register.
// Throughput: one request per cycle while the output is not stalled.
// Each stage holds its own valid bit and loads when it is empty or the stage after
// it moves, so an output stall only backs up stages that are occupied.
// Reset clears the valid bits and the output valid; the datapath needs no clearing.
`timescale 1ns / 1ps
`include "civil_date_day_number_convert_defines.svh"

module civil_date_day_number_convert import cdc_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [13:0]        year_in,
  input  logic [3:0]         month_in,
  input  logic [4:0]         day_in,
  input  logic signed [22:0] day_number_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [22:0] day_number_out,
  output logic [13:0]        year_out,
  output logic [3:0]         month_out,
  output logic [4:0]         day_out,
  output logic               valid_res
);

  logic [NumStages-1:0] vld;
  logic [NumStages-1:0] vld_next;
  logic [NumStages-1:0] mode_pipe;
  logic                 load_out;
  pipe_ctrl_t           ctrl;

  assign load_out = !out_valid || !out_stall;

  // A stage moves when it or any stage after it is empty, or the output moves.
  always_comb begin
    logic moves;
    moves = load_out;
    for (int k = NumStages - 1; k >= 0; k--) begin
      moves        = moves || !vld[k];
      ctrl.load[k] = moves;
    end
  end

  assign in_stall    = !ctrl.load[0];
  assign vld_next    = (ctrl.load & {vld[NumStages-2:0], in_valid}) | (~ctrl.load & vld);

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      vld <= vld_next;
      if (load_out) begin
        out_valid <= vld[NumStages-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load[0]) begin
      mode_pipe[0] <= mode;
    end
    for (int k = 1; k < NumStages; k++) begin
      if (ctrl.load[k]) begin
        mode_pipe[k] <= mode_pipe[k-1];
      end
    end
  end

  logic [22:0] td_day_number;
  logic        td_ok;
  logic [13:0] fd_year;
  logic [3:0]  fd_month;
  logic [4:0]  fd_day;
  logic        fd_ok;

  cdc_to_days u_to_days (
    .clk        (clk),
    .ctrl       (ctrl),
    .year_in    (year_in),
    .month_in   (month_in),
    .day_in     (day_in),
    .day_number (td_day_number),
    .ok         (td_ok)
  );

  cdc_from_days u_from_days (
    .clk           (clk),
    .ctrl          (ctrl),
    .day_number_in (day_number_in),
    .year          (fd_year),
    .month         (fd_month),
    .day           (fd_day),
    .ok            (fd_ok)
  );

  // Fields not produced by the request's direction, and all fields of a
  // rejected request, are zero.
  logic last_mode;
  logic take_date;
  logic take_days;

  assign last_mode = mode_pipe[NumStages-1];
  assign take_date = last_mode && fd_ok;
  assign take_days = !last_mode && td_ok;

  always_ff @(posedge clk) begin
    if (load_out) begin
      day_number_out <= take_days ? $signed(td_day_number) : '0;
      year_out       <= take_date ? fd_year : '0;
      month_out      <= take_date ? fd_month : '0;
      day_out        <= take_date ? fd_day : '0;
      valid_res      <= take_date || take_days;
    end
  end

  `CDC_ASSERT_IMP(a_invalid_zero, out_valid && !valid_res, (day_number_out == 23'sd0) && (year_out == 14'd0) && (month_out == 4'd0) && (day_out == 5'd0))
  `CDC_ASSERT_IMP(a_date_excludes_days, out_valid && (year_out != 14'd0), valid_res && (day_number_out == 23'sd0) && (month_out >= 4'd1) && (month_out <= 4'd12) && (day_out >= 5'd1))
  `CDC_ASSERT_IMP(a_stall_only_when_full, in_stall, (&vld) && out_valid && out_stall)
  `CDC_ASSERT_NXT(a_last_stage_drains, vld[NumStages-1] && load_out, out_valid)

endmodule

// File: tb/sv/civil_date_day_number_convert_tb.sv
// Self-checking testbench for the civil date / day number converter.
// Needs civil_date_day_number_convert and cdc_pkg; has its own predictor of the
// Gregorian conversion and checks every result in order.
`timescale 1ns / 1ps

module civil_date_day_number_convert_tb;

  localparam int FirstDayNumber = -719162;  // 0001-01-01
  localparam int LastDayNumber  = 2932896;  // 9999-12-31
  localparam int MarchEpochBias = 719468;   // days from 0000-03-01 to 1970-01-01
  localparam int DaysPerEra     = 146097;
  localparam int YearsPerEra    = 400;
  localparam int RandomRequests = 750;
  localparam int TailRequests   = 100;      // no idling on either side for these
  localparam int DrainCycles    = 30;

  typedef struct packed {
    logic               mode;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic signed [22:0] number;
  } conv_req_t;

  typedef struct packed {
    logic signed [22:0] number;
    logic [13:0]        year;
    logic [3:0]         month;
    logic [4:0]         day;
    logic               ok;
  } conv_res_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               mode = 1'b0;
  logic [13:0]        year_in = '0;
  logic [3:0]         month_in = '0;
  logic [4:0]         day_in = '0;
  logic signed [22:0] day_number_in = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [22:0] day_number_out;
  logic [13:0]        year_out;
  logic [3:0]         month_out;
  logic [4:0]         day_out;
  logic               valid_res;

  conv_req_t pending_reqs[$];
  conv_res_t expected_dates[$];
  int        total_reqs = 0;
  int        n_accepted = 0;
  int        err_count = 0;
  int        send_gap = 0;
  int        send_idle_pct = 0;
  int        stall_left = 0;
  int        stall_pct = 0;

  civil_date_day_number_convert u_top (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .mode           (mode),
    .year_in        (year_in),
    .month_in       (month_in),
    .day_in         (day_in),
    .day_number_in  (day_number_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .day_number_out (day_number_out),
    .year_out       (year_out),
    .month_out      (month_out),
    .day_out        (day_out),
    .valid_res      (valid_res)
  );

  always #5 clk = ~clk;

  function automatic bit is_leap(int unsigned y);
    return ((y % 4) == 0 && (y % 100) != 0) || (y % 400) == 0;
  endfunction

  function automatic int unsigned month_length(int unsigned y, int unsigned m);
    int unsigned lengths[12];
    lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
    if (m < 1 || m > 12) return 0;
    if (m == 2 && is_leap(y)) return 29;
    return lengths[m - 1];
  endfunction

  // Years are counted from March so that the leap day falls at the end of a year.
  function automatic conv_res_t predict_conversion(conv_req_t r);
    conv_res_t   res;
    int unsigned y, m, d, adj_year, era, yoe, mar_month, doy, doe, shifted;
    int          n;
    res = '0;
    y = r.year;
    m = r.month;
    d = r.day;
    n = r.number;
    if (r.mode == 1'b0) begin
      if (y >= 1 && y <= 9999 && d >= 1 && d <= month_length(y, m)) begin
        adj_year = y - ((m <= 2) ? 1 : 0);
        era = adj_year / YearsPerEra;
        yoe = adj_year - era * YearsPerEra;
        mar_month = (m > 2) ? (m - 3) : (m + 9);
        doy = (153 * mar_month + 2) / 5 + d - 1;
        doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
        res.number = 23'(int'(era * DaysPerEra + doe) - MarchEpochBias);
        res.ok = 1'b1;
      end
    end else if (n >= FirstDayNumber && n <= LastDayNumber) begin
      shifted = n + MarchEpochBias;
      era = shifted / DaysPerEra;
      doe = shifted - era * DaysPerEra;
      yoe = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
      doy = doe - (365 * yoe + yoe / 4 - yoe / 100);
      mar_month = (5 * doy + 2) / 153;
      d = doy - (153 * mar_month + 2) / 5 + 1;
      m = (mar_month < 10) ? (mar_month + 3) : (mar_month - 9);
      res.year = 14'(yoe + era * YearsPerEra + ((m <= 2) ? 1 : 0));
      res.month = 4'(m);
      res.day = 5'(d);
      res.ok = 1'b1;
    end
    return res;
  endfunction

  // Fields that the selected mode ignores are filled with random bits.
  task automatic queue_date(int unsigned y, int unsigned m, int unsigned d);
    conv_req_t r;
    r.mode = 1'b0;
    r.year = 14'(y);
    r.month = 4'(m);
    r.day = 5'(d);
    r.number = 23'($urandom());
    pending_reqs = {pending_reqs, r};
    total_reqs++;
  endtask

  task automatic queue_day_number(int n);
    conv_req_t r;
    r.mode = 1'b1;
    r.year = 14'($urandom());
    r.month = 4'($urandom());
    r.day = 5'($urandom());
    r.number = 23'(n);
    pending_reqs = {pending_reqs, r};
    total_reqs++;
  endtask

  task automatic queue_random_date();
    int unsigned y, m, d, pick;
    pick = $urandom_range(0, 99);
    y = $urandom_range(1, 9999);
    m = $urandom_range(1, 12);
    d = $urandom_range(1, month_length(y, m));
    if (pick >= 70 && pick < 80) begin
      // Last day of the month or one past it, often February of a multiple of 4 or 100.
      if ($urandom_range(0, 1)) begin
        m = 2;
        y = ($urandom_range(0, 1) ? 100 : 4) * $urandom_range(1, 24);
      end
      d = month_length(y, m) + $urandom_range(0, 1);
    end else if (pick >= 80 && pick < 90) begin
      y = $urandom_range(0, 1) ? $urandom_range(0, 2) : $urandom_range(9997, 10001);
    end else if (pick >= 90) begin
      y = $urandom_range(0, 16383);
      m = $urandom_range(0, 15);
      d = $urandom_range(0, 31);
    end
    queue_date(y, m, d);
  endtask

  task automatic queue_random_day_number();
    int          pick;
    logic [31:0] raw;
    pick = $urandom_range(0, 99);
    raw = $urandom();
    if (pick < 75)
      queue_day_number(int'($urandom_range(0, LastDayNumber - FirstDayNumber)) +
                       FirstDayNumber);
    else if (pick < 85)
      queue_day_number(($urandom_range(0, 1) ? FirstDayNumber : LastDayNumber) +
                       int'($urandom_range(0, 6)) - 3);
    else
      queue_day_number(int'(23'(raw[22:0])));
  endtask

  task automatic check_field(string name, int expected, int actual);
    if (expected != actual) begin
      $error("%s: expected %0d, got %0d", name, expected, actual);
      err_count++;
    end
  endtask

  // Request driver: a request stays on the port until it is taken.
  always @(posedge clk) begin
    conv_req_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_dates = {expected_dates, predict_conversion(
          {mode, year_in, month_in, day_in, day_number_in})};
        n_accepted <= n_accepted + 1;
        if (n_accepted % 50 == 0) begin
          case ($urandom_range(0, 2))
            0:       send_idle_pct <= 0;
            1:       send_idle_pct <= 15;
            default: send_idle_pct <= 50;
          endcase
        end
      end
      if (!in_valid || !in_stall) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() == 0) begin
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > TailRequests &&
                     $urandom_range(0, 99) < send_idle_pct) begin
          send_gap <= $urandom_range(0, 3);
          in_valid <= 1'b0;
        end else begin
          nxt = pending_reqs.pop_front();
          in_valid <= 1'b1;
          mode <= nxt.mode;
          year_in <= nxt.year;
          month_in <= nxt.month;
          day_in <= nxt.day;
          day_number_in <= nxt.number;
        end
      end
    end
  end

  // Output stall in bursts; the rate changes now and then.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else begin
      if ($urandom_range(0, 63) == 0) stall_pct <= $urandom_range(0, 2) * 25;
      if (stall_left > 0) begin
        stall_left <= stall_left - 1;
        out_stall <= 1'b1;
      end else if (pending_reqs.size() > TailRequests &&
                   $urandom_range(0, 99) < stall_pct) begin
        stall_left <= $urandom_range(0, 3);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    conv_res_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_dates.size() == 0) begin
        $error("result with no request outstanding");
        err_count++;
      end else begin
        want = expected_dates.pop_front();
        check_field("day_number_out", want.number, day_number_out);
        check_field("year_out", want.year, year_out);
        check_field("month_out", want.month, month_out);
        check_field("day_out", want.day, day_out);
        check_field("valid_res", want.ok, valid_res);
      end
    end
  end

  initial begin
    // Range ends, the epoch and its eve.
    queue_date(1, 1, 1);
    queue_date(9999, 12, 31);
    queue_date(1970, 1, 1);
    queue_date(1969, 12, 31);
    // Leap-year rule: every fourth year, not centuries, but every fourth century.
    queue_date(2000, 2, 29);
    queue_date(1900, 2, 29);
    queue_date(2004, 2, 29);
    queue_date(2001, 2, 29);
    queue_date(2000, 3, 1);
    // Invalid years, months and days.
    queue_date(0, 6, 15);
    queue_date(10000, 1, 1);
    queue_date(16383, 15, 31);
    queue_date(2020, 0, 10);
    queue_date(2020, 13, 10);
    queue_date(2020, 5, 0);
    queue_date(2021, 4, 31);
    queue_day_number(FirstDayNumber);
    queue_day_number(FirstDayNumber - 1);
    queue_day_number(LastDayNumber);
    queue_day_number(LastDayNumber + 1);
    queue_day_number(0);
    queue_day_number(-1);
    queue_day_number(11016);
    queue_day_number(4194303);
    queue_day_number(-4194304);
    repeat (RandomRequests) begin
      if ($urandom_range(0, 1)) queue_random_date();
      else queue_random_day_number();
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (n_accepted != total_reqs) @(posedge clk);
    while (expected_dates.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (err_count == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #2000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
